@@ sv/packet_deframer_crc8_unit_assert.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the packet deframer
// Concurrent checks clocked on clk and disabled while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef PACKET_DEFRAMER_CRC8_UNIT_ASSERT_SVH
`define PACKET_DEFRAMER_CRC8_UNIT_ASSERT_SVH

// Check a property in every cycle out of reset
`define PDC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition in one cycle implies another in the next cycle
`define PDC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/pdc_pkg.sv @@
// ---------------------------------------------------------------------------
// pdc_pkg
// Shared constants, codes, item types and the CRC-8 update for the deframer.
// ---------------------------------------------------------------------------
`default_nettype none

package pdc_pkg;

	// Largest payload plus one; a length byte must stay below this
	localparam int PAYLOAD_MAX = 32;
	localparam int LEN_W       = $clog2(PAYLOAD_MAX);
	localparam int CNT_W       = $clog2(PAYLOAD_MAX + 1);
	localparam int LIM_W       = 9;

	localparam logic [7:0] START_MARKER_RST = 8'd213;

	// Frame phases
	localparam logic [2:0] PH_START   = 3'd0;
	localparam logic [2:0] PH_LEN     = 3'd1;
	localparam logic [2:0] PH_PAYLOAD = 3'd2;
	localparam logic [2:0] PH_CRC     = 3'd3;
	localparam logic [2:0] PH_DONE    = 3'd4;

	// Error codes
	localparam logic [1:0] ERR_NONE   = 2'd0;
	localparam logic [1:0] ERR_NOISE  = 2'd1;
	localparam logic [1:0] ERR_LENGTH = 2'd2;
	localparam logic [1:0] ERR_CRC    = 2'd3;

	// Request kinds
	localparam logic KIND_BYTE    = 1'b0;
	localparam logic KIND_RESTART = 1'b1;

	localparam logic [7:0] CRC_POLY = 8'h8C;

	typedef struct packed {
		logic       kind;
		logic [7:0] data_byte;
	} in_item_t;

	typedef struct packed {
		logic [2:0] frame_state;
		logic [1:0] fault_code;
		logic [7:0] payload_byte;
		logic [4:0] payload_index;
		logic       payload_valid;
		logic       packet_ok;
		logic [7:0] running_crc;
		logic [4:0] payload_length;
	} out_item_t;

	// Reflected CRC-8, one byte, unrolled bit by bit
	function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

@@ sv/pdc_stream_if.sv @@
// ---------------------------------------------------------------------------
// pdc_in_if / pdc_out_if
// Valid/ready channels for byte requests and deframer results.
// ---------------------------------------------------------------------------
`default_nettype none

interface pdc_in_if import pdc_pkg::*;;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] data_byte;

	modport source (output valid, output kind, output data_byte, input ready);
	modport sink   (input valid, input kind, input data_byte, output ready);
endinterface

interface pdc_out_if import pdc_pkg::*;;
	logic       valid;
	logic       ready;
	logic [2:0] frame_state;
	logic [1:0] fault_code;
	logic [7:0] payload_byte;
	logic [4:0] payload_index;
	logic       payload_valid;
	logic       packet_ok;
	logic [7:0] running_crc;
	logic [4:0] payload_length;

	modport source (
		output valid, output frame_state, output fault_code, output payload_byte,
		output payload_index, output payload_valid, output packet_ok,
		output running_crc, output payload_length, input ready
	);
	modport sink (
		input valid, input frame_state, input fault_code, input payload_byte,
		input payload_index, input payload_valid, input packet_ok,
		input running_crc, input payload_length, output ready
	);
endinterface

`default_nettype wire

@@ sv/pdc_in_stage.sv @@
// ---------------------------------------------------------------------------
// pdc_in_stage
// Input register: captures one request and holds it until it is processed.
// ---------------------------------------------------------------------------
`default_nettype none

module pdc_in_stage import pdc_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	input  wire in_item_t in_item,
	input  wire logic     space,
	output logic          valid_s1,
	output in_item_t      item_s1
);

	logic advance;

	// Take a new request when empty or when the held one moves on
	assign advance  = !valid_s1 || space;
	assign in_ready = advance;

	// Track occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= in_valid;
		end
	end

	// Hold the payload
	always_ff @(posedge clk) begin
		if (advance && in_valid) begin
			item_s1 <= in_item;
		end
	end

endmodule

`default_nettype wire

@@ sv/pdc_frame_fsm.sv @@
// ---------------------------------------------------------------------------
// pdc_frame_fsm
// Frame state machine, CRC accumulator and start-marker register. Computes
// the result for the held request and updates state when it is processed.
// ---------------------------------------------------------------------------
`default_nettype none

module pdc_frame_fsm import pdc_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic [7:0] cfg_wdata,
	input  wire logic       fire,
	input  wire in_item_t   item_s1,
	output out_item_t       result
);

	`include "packet_deframer_crc8_unit_assert.svh"

	logic [7:0]       marker_q;
	logic [2:0]       phase_q,   phase_n;
	logic [LEN_W-1:0] len_q,     len_n;
	logic [CNT_W-1:0] cnt_q,     cnt_n;
	logic [7:0]       crc_q,     crc_n;
	logic [1:0]       err_q,     err_n;
	logic [7:0]       crc_upd;
	logic             pvalid;
	logic             ok;
	logic [7:0]       b;
	logic             in_done;
	logic             in_payload;
	logic             state_clear;
	logic             fire_restart;
	logic             fire_done_byte;

	assign b       = item_s1.data_byte;
	assign crc_upd = crc8_update(crc_q, b);

	// Next state for the held request
	always_comb begin
		phase_n = phase_q;
		len_n   = len_q;
		cnt_n   = cnt_q;
		crc_n   = crc_q;
		err_n   = err_q;
		pvalid  = 1'b0;
		ok      = 1'b0;
		if (item_s1.kind == KIND_RESTART) begin
			phase_n = PH_START;
			len_n   = '0;
			cnt_n   = '0;
			crc_n   = '0;
			err_n   = ERR_NONE;
		end else begin
			case (phase_q)
				PH_START: begin
					if (b == marker_q) begin
						phase_n = PH_LEN;
					end else begin
						phase_n = PH_DONE;
						err_n   = ERR_NOISE;
					end
				end
				PH_LEN: begin
					if ({1'b0, b} < LIM_W'(PAYLOAD_MAX)) begin
						len_n   = LEN_W'(b);
						phase_n = (b == 8'd0) ? PH_CRC : PH_PAYLOAD;
					end else begin
						phase_n = PH_DONE;
						err_n   = ERR_LENGTH;
					end
				end
				PH_PAYLOAD: begin
					if (cnt_q < CNT_W'(PAYLOAD_MAX)) begin
						crc_n  = crc_upd;
						pvalid = 1'b1;
						cnt_n  = cnt_q + CNT_W'(1);
					end
					if (cnt_n >= CNT_W'(len_q)) begin
						phase_n = PH_CRC;
					end
				end
				PH_CRC: begin
					phase_n = PH_DONE;
					if (crc_q == b) begin
						ok = 1'b1;
					end else begin
						err_n = ERR_CRC;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Assemble the result
	always_comb begin
		result.frame_state    = phase_n;
		result.fault_code     = err_n;
		result.payload_byte   = pvalid ? b : 8'd0;
		result.payload_index  = pvalid ? 5'(cnt_q) : 5'd0;
		result.payload_valid  = pvalid;
		result.packet_ok      = ok;
		result.running_crc    = crc_n;
		result.payload_length = 5'(len_n);
	end

	// Advance state when the request is processed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			len_q   <= '0;
			cnt_q   <= '0;
			crc_q   <= '0;
			err_q   <= ERR_NONE;
		end else if (fire) begin
			phase_q <= phase_n;
			len_q   <= len_n;
			cnt_q   <= cnt_n;
			crc_q   <= crc_n;
			err_q   <= err_n;
		end
	end

	// Hold the start marker
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			marker_q <= START_MARKER_RST;
		end else if (cfg_we) begin
			marker_q <= cfg_wdata;
		end
	end

	// Terms for the checks below
	assign in_done        = (phase_q == PH_DONE);
	assign in_payload     = (phase_q == PH_PAYLOAD);
	assign state_clear    = (phase_q == PH_START) && (crc_q == 8'd0) && (cnt_q == '0);
	assign fire_restart   = fire && (item_s1.kind == KIND_RESTART);
	assign fire_done_byte = fire && (item_s1.kind == KIND_BYTE) && in_done;

	`PDC_ASSERT(a_err_ends_packet, (err_q == ERR_NONE) || in_done, "error outside done phase")
	`PDC_ASSERT(a_count_below_len, !in_payload || (cnt_q < CNT_W'(len_q)), "count overran length")
	`PDC_ASSERT_NEXT(a_restart_clears, fire_restart, state_clear, "restart did not clear state")
	`PDC_ASSERT_NEXT(a_done_holds_crc, fire_done_byte, $stable(crc_q) && in_done, "done byte moved state")

endmodule

`default_nettype wire

@@ sv/pdc_out_stage.sv @@
// ---------------------------------------------------------------------------
// pdc_out_stage
// Result register: holds one result until the downstream side takes it.
// ---------------------------------------------------------------------------
`default_nettype none

module pdc_out_stage import pdc_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      fire,
	input  wire out_item_t result,
	output logic           space,
	output logic           out_valid,
	input  wire logic      out_ready,
	output out_item_t      out_item
);

	// Free when empty or when the held result leaves this cycle
	assign space = !out_valid || out_ready;

	// Track occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (space) begin
			out_valid <= fire;
		end
	end

	// Load a new result
	always_ff @(posedge clk) begin
		if (fire) begin
			out_item <= result;
		end
	end

endmodule

`default_nettype wire

@@ sv/packet_deframer_crc8_unit.sv @@
// ---------------------------------------------------------------------------
// packet_deframer_crc8_unit
// Length-prefixed packet deframer with CRC-8 (reflected 0x8C, init 0) check.
//
//   Channel  Dir  Carries
//   item     in   kind, data_byte (byte or restart request)
//   result   out  frame_state, fault_code, payload byte/index/valid,
//                 packet_ok, running_crc, payload_length
//   cfg      in   cfg_we / cfg_wdata: start marker byte
//
// One request per cycle unless the result side stalls; a request's result is
// offered from the result register after it leaves the input register.
// The CRC byte update and the frame state machine sit between the input
// register and the result register. Reset clears valid flags and frame
// state; the start marker returns to 0xD5. A stalled result holds in the
// result register while one more request waits in the input register.
// ---------------------------------------------------------------------------
`default_nettype none

module packet_deframer_crc8_unit import pdc_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	pdc_in_if.sink          item,
	pdc_out_if.source       result,
	input  wire logic       cfg_we,
	input  wire logic [7:0] cfg_wdata
);

	in_item_t  in_item;
	in_item_t  item_s1;
	out_item_t res_c;
	out_item_t res_q;
	logic      valid_s1;
	logic      space;
	logic      fire;

	assign in_item.kind      = item.kind;
	assign in_item.data_byte = item.data_byte;

	// Process the held request when the result register has room
	assign fire = valid_s1 && space;

	pdc_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item.valid),
		.in_ready (item.ready),
		.in_item  (in_item),
		.space    (space),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	pdc_frame_fsm u_fsm (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.fire      (fire),
		.item_s1   (item_s1),
		.result    (res_c)
	);

	pdc_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.result    (res_c),
		.space     (space),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.out_item  (res_q)
	);

	// Drive the result channel
	assign result.frame_state    = res_q.frame_state;
	assign result.fault_code     = res_q.fault_code;
	assign result.payload_byte   = res_q.payload_byte;
	assign result.payload_index  = res_q.payload_index;
	assign result.payload_valid  = res_q.payload_valid;
	assign result.packet_ok      = res_q.packet_ok;
	assign result.running_crc    = res_q.running_crc;
	assign result.payload_length = res_q.payload_length;

endmodule

`default_nettype wire
